// File: src/tsq_pkg.sv
`default_nettype none

package tsq_pkg;

    localparam int ID_W        = 16;
    localparam int CAP_W       = 7;
    localparam int PERIOD_W    = 8;
    localparam int CLASS_W     = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 2;

    localparam logic [CLASS_W-1:0] CLASS_CONTROL = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_HEADER  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DATA    = 2'd2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_DATA_CAPACITY = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WRR_PERIOD    = 1'd1;

    localparam logic [CAP_W-1:0]    CAP_RESET    = 7'd32;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;

    typedef struct packed {
        logic            pull_request;
        logic            header_only;
        logic            nack_flag;
        logic            syn_flag;
        logic            ack_flag;
        logic [ID_W-1:0] packet_id;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] control_count;
        logic [COUNT_OUT_W-1:0] header_count;
        logic [COUNT_OUT_W-1:0] data_count;
        logic                   dropped;
        logic                   trimmed_on_push;
        logic                   out_trimmed;
        logic [ID_W-1:0]        out_packet_id;
        logic                   packet_valid;
    } out_item_t;

    typedef struct packed {
        logic exec;
        logic load_out;
        logic rem_start;
    } dp_cmd_t;

    typedef struct packed {
        logic rem_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/trimming_switch_queue_wrr.sv
// Each request is executed at acceptance into staging registers; the block then
// waits, stalling while a held result is not taken, to load the output register,
// and takes no new request before that. The result stands in an output register
// while the next request is taken. A write of wrr_period holds the input off while
// the bit-serial remainder unit tests the serve counter modulo the new period.
// Reset is synchronous and active low: all queues empty, counter zero, registers 32 and 10.
`default_nettype none

module trimming_switch_queue_wrr
    import tsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // packet_id, ack_flag, syn_flag, nack_flag, header_only, pull_request
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // command
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // packet_valid, out_packet_id, out_trimmed, trimmed_on_push, dropped,
    // data_count, header_count, control_count
    output logic [M_TDATA_W-1:0]       m_tdata,
    // queue_class
    output logic [M_TUSER_W-1:0]       m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

    dp_cmd_t            cmd;
    dp_status_t         status;
    in_item_t           s_item;
    out_item_t          m_item;
    logic [CLASS_W-1:0] m_class;

    assign s_item  = in_item_t'(s_tdata[IN_W-1:0]);
    assign m_tdata = M_TDATA_W'(m_item);
    assign m_tuser = M_TUSER_W'(m_class);

    tsq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cmd      (cmd),
        .status   (status)
    );

    tsq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_command (s_tuser[0]),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_item    (m_item),
        .m_class   (m_class)
    );

endmodule

`default_nettype wire

// File: src/tsq_rem.sv
`default_nettype none

module tsq_rem
    import tsq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [PERIOD_W-1:0] dividend,
    input  wire logic [PERIOD_W-1:0] divisor,
    output logic                     busy,
    output logic                     done,
    output logic                     rem_zero
);

    localparam int STEP_W = $clog2(PERIOD_W);

    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] dvd_reg;
    logic [PERIOD_W-1:0] dvs_reg;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W-1:0] rem_next;

    always_comb begin
        trial = {rem_reg, dvd_reg[PERIOD_W-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = PERIOD_W'(trial - {1'b0, dvs_reg});
        end else begin
            rem_next = trial[PERIOD_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (step_reg == STEP_W'(PERIOD_W - 1));
    assign rem_zero = (rem_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            rem_reg  <= '0;
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[PERIOD_W-2:0], 1'b0};
            step_reg <= step_reg + 1'b1;
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/tsq_datapath.sv
`default_nettype none

module tsq_datapath
    import tsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic                  s_command,
    input  wire in_item_t              s_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output out_item_t                  m_item,
    output logic [CLASS_W-1:0]         m_class
);

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        ptr_inc = (ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    logic [CAP_W-1:0]    cap_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] counter_reg;
    logic                rem_zero_reg;

    logic [CW-1:0] count_reg  [0:2];
    logic [AW-1:0] rd_ptr_reg [0:2];
    logic [AW-1:0] wr_ptr_reg [0:2];

    logic [ID_W-1:0] ctrl_mem [0:QUEUE_DEPTH-1];
    logic [ID_W:0]   hdr_mem  [0:QUEUE_DEPTH-1];
    logic [ID_W-1:0] data_mem [0:QUEUE_DEPTH-1];

    logic [ID_W-1:0] ctrl_rd_reg;
    logic [ID_W:0]   hdr_rd_reg;
    logic [ID_W-1:0] data_rd_reg;

    logic               st_valid_reg;
    logic [CLASS_W-1:0] st_class_reg;
    logic               st_tpush_reg;
    logic               st_drop_reg;

    out_item_t          out_item_reg;
    logic [CLASS_W-1:0] out_class_reg;

    logic                is_ctrl;
    logic                is_hdr;
    logic                data_over;
    logic                push_trim;
    logic [CLASS_W-1:0]  push_class;
    logic                target_full;
    logic                has_ctrl;
    logic                has_hdr;
    logic                has_data;
    logic [CLASS_W-1:0]  pull_class;
    logic                pull_valid;
    logic                pull_adv;
    logic                do_push;
    logic                do_pop;
    logic                is_push;
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W:0]   counter_inc;
    logic [PERIOD_W-1:0] counter_adv;
    logic [PERIOD_W-1:0] rem_divisor;
    logic                rem_busy;
    logic                rem_done;
    logic                rem_is_zero;
    logic [ID_W-1:0]     pop_id;
    logic                pop_trim;

    assign is_push   = (s_command == CMD_PUSH);
    assign is_ctrl   = s_item.ack_flag | s_item.syn_flag | s_item.nack_flag;
    assign is_hdr    = s_item.header_only | s_item.pull_request;
    assign data_over = (CMP_W'(count_reg[CLASS_DATA]) >= CMP_W'(cap_reg))
                    || (count_reg[CLASS_DATA] == CW'(QUEUE_DEPTH));
    assign push_trim = !is_ctrl && !is_hdr && data_over;

    always_comb begin
        priority if (is_ctrl) begin
            push_class = CLASS_CONTROL;
        end else if (is_hdr || data_over) begin
            push_class = CLASS_HEADER;
        end else begin
            push_class = CLASS_DATA;
        end
    end

    assign target_full = (count_reg[push_class] == CW'(QUEUE_DEPTH));

    assign has_ctrl = (count_reg[CLASS_CONTROL] != '0);
    assign has_hdr  = (count_reg[CLASS_HEADER] != '0);
    assign has_data = (count_reg[CLASS_DATA] != '0);

    always_comb begin
        pull_valid = 1'b1;
        pull_adv   = 1'b0;
        priority if (has_ctrl) begin
            pull_class = CLASS_CONTROL;
        end else if (has_hdr && has_data) begin
            pull_class = rem_zero_reg ? CLASS_DATA : CLASS_HEADER;
            pull_adv   = 1'b1;
        end else if (has_hdr) begin
            pull_class = CLASS_HEADER;
        end else if (has_data) begin
            pull_class = CLASS_DATA;
        end else begin
            pull_class = CLASS_CONTROL;
            pull_valid = 1'b0;
        end
    end

    assign do_push = cmd.exec && is_push && !target_full;
    assign do_pop  = cmd.exec && !is_push && pull_valid;

    assign period_eff  = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign counter_inc = {1'b0, counter_reg} + 1'b1;
    assign counter_adv = (counter_inc >= {1'b0, period_eff}) ? '0
                                                             : counter_inc[PERIOD_W-1:0];
    assign rem_divisor = (cfg_wdata[PERIOD_W-1:0] == '0) ? PERIOD_W'(1)
                                                          : cfg_wdata[PERIOD_W-1:0];

    tsq_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.rem_start),
        .dividend (counter_reg),
        .divisor  (rem_divisor),
        .busy     (rem_busy),
        .done     (rem_done),
        .rem_zero (rem_is_zero)
    );

    assign status.rem_busy = rem_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DATA_CAPACITY: cap_reg    <= cfg_wdata[CAP_W-1:0];
                REG_WRR_PERIOD:    period_reg <= cfg_wdata[PERIOD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg  <= '0;
            rem_zero_reg <= 1'b1;
        end else if (do_pop && pull_adv) begin
            counter_reg  <= counter_adv;
            rem_zero_reg <= (counter_adv == '0);
        end else if (rem_done) begin
            rem_zero_reg <= rem_is_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                count_reg[i]  <= '0;
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (do_push && (push_class == CLASS_W'(i))) begin
                    wr_ptr_reg[i] <= ptr_inc(wr_ptr_reg[i]);
                    count_reg[i]  <= count_reg[i] + 1'b1;
                end
                if (do_pop && (pull_class == CLASS_W'(i))) begin
                    rd_ptr_reg[i] <= ptr_inc(rd_ptr_reg[i]);
                    count_reg[i]  <= count_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push && (push_class == CLASS_CONTROL)) begin
            ctrl_mem[wr_ptr_reg[CLASS_CONTROL]] <= s_item.packet_id;
        end
        if (do_pop && (pull_class == CLASS_CONTROL)) begin
            ctrl_rd_reg <= ctrl_mem[rd_ptr_reg[CLASS_CONTROL]];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push && (push_class == CLASS_HEADER)) begin
            hdr_mem[wr_ptr_reg[CLASS_HEADER]] <= {push_trim, s_item.packet_id};
        end
        if (do_pop && (pull_class == CLASS_HEADER)) begin
            hdr_rd_reg <= hdr_mem[rd_ptr_reg[CLASS_HEADER]];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push && (push_class == CLASS_DATA)) begin
            data_mem[wr_ptr_reg[CLASS_DATA]] <= s_item.packet_id;
        end
        if (do_pop && (pull_class == CLASS_DATA)) begin
            data_rd_reg <= data_mem[rd_ptr_reg[CLASS_DATA]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            st_valid_reg <= !is_push && pull_valid;
            st_class_reg <= is_push ? push_class : pull_class;
            st_tpush_reg <= is_push && push_trim;
            st_drop_reg  <= is_push && target_full;
        end
    end

    always_comb begin
        pop_id   = '0;
        pop_trim = 1'b0;
        if (st_valid_reg) begin
            unique case (st_class_reg)
                CLASS_CONTROL: pop_id = ctrl_rd_reg;
                CLASS_HEADER: begin
                    pop_id   = hdr_rd_reg[ID_W-1:0];
                    pop_trim = hdr_rd_reg[ID_W];
                end
                CLASS_DATA:    pop_id = data_rd_reg;
                default:       pop_id = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_item_reg.packet_valid    <= st_valid_reg;
            out_item_reg.out_packet_id   <= pop_id;
            out_item_reg.out_trimmed     <= pop_trim;
            out_item_reg.trimmed_on_push <= st_tpush_reg;
            out_item_reg.dropped         <= st_drop_reg;
            out_item_reg.data_count      <= COUNT_OUT_W'(count_reg[CLASS_DATA]);
            out_item_reg.header_count    <= COUNT_OUT_W'(count_reg[CLASS_HEADER]);
            out_item_reg.control_count   <= COUNT_OUT_W'(count_reg[CLASS_CONTROL]);
            out_class_reg                <= st_class_reg;
        end
    end

    assign m_item  = out_item_reg;
    assign m_class = out_class_reg;

endmodule

`default_nettype wire

// File: src/tsq_ctrl.sv
`default_nettype none

module tsq_ctrl
    import tsq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    output dp_cmd_t                    cmd,
    input  wire dp_status_t            status
);

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_tready      = (state_reg == ST_IDLE) && !status.rem_busy && !cfg_we;
    assign cmd.exec      = s_tvalid && s_tready;
    assign cmd.load_out  = (state_reg == ST_WAIT) && (!m_valid_reg || m_tready);
    assign cmd.rem_start = cfg_we && (cfg_addr == REG_WRR_PERIOD);
    assign m_tvalid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.exec) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (cmd.load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tsq_pkg::*;

    localparam int DEPTH = 64;

    localparam logic [4:0] F_NONE = 5'b00000;
    localparam logic [4:0] F_ACK  = 5'b00001;
    localparam logic [4:0] F_SYN  = 5'b00010;
    localparam logic [4:0] F_NACK = 5'b00100;
    localparam logic [4:0] F_HDR  = 5'b01000;
    localparam logic [4:0] F_PULL = 5'b10000;

    class trim_queue_scoreboard;
        logic [ID_W:0]        control_q[$];
        logic [ID_W:0]        header_q[$];
        logic [ID_W:0]        data_q[$];
        logic [CAP_W-1:0]     capacity;
        logic [PERIOD_W-1:0]  period;
        int                   serve_count;
        out_item_t            expected_results[$];
        logic [CLASS_W-1:0]   expected_classes[$];
        int                   failures;

        function new();
            capacity    = CAP_RESET;
            period      = PERIOD_RESET;
            serve_count = 0;
            failures    = 0;
        endfunction

        function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            if (addr == REG_DATA_CAPACITY) begin
                capacity = value[CAP_W-1:0];
            end else begin
                period = value;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(logic cmd, in_item_t req);
            out_item_t          res;
            logic [CLASS_W-1:0] cls;
            logic [ID_W:0]      entry;
            int                 eff_period;
            res   = '0;
            cls   = CLASS_CONTROL;
            entry = '0;
            if (cmd == CMD_PUSH) begin
                if (req.ack_flag | req.syn_flag | req.nack_flag) begin
                    cls = CLASS_CONTROL;
                    if (control_q.size() < DEPTH) control_q.push_back({1'b0, req.packet_id});
                    else res.dropped = 1'b1;
                end else if (req.header_only | req.pull_request) begin
                    cls = CLASS_HEADER;
                    if (header_q.size() < DEPTH) header_q.push_back({1'b0, req.packet_id});
                    else res.dropped = 1'b1;
                end else if (data_q.size() >= capacity || data_q.size() >= DEPTH) begin
                    cls = CLASS_HEADER;
                    res.trimmed_on_push = 1'b1;
                    if (header_q.size() < DEPTH) header_q.push_back({1'b1, req.packet_id});
                    else res.dropped = 1'b1;
                end else begin
                    cls = CLASS_DATA;
                    if (data_q.size() < DEPTH) data_q.push_back({1'b0, req.packet_id});
                    else res.dropped = 1'b1;
                end
            end else begin
                eff_period = (period == 0) ? 1 : int'(period);
                if (control_q.size() != 0) begin
                    res.packet_valid = 1'b1;
                    cls = CLASS_CONTROL;
                    entry = control_q.pop_front();
                end else if (header_q.size() != 0 && data_q.size() != 0) begin
                    res.packet_valid = 1'b1;
                    if (serve_count % eff_period == 0) begin
                        cls = CLASS_DATA;
                        entry = data_q.pop_front();
                    end else begin
                        cls = CLASS_HEADER;
                        entry = header_q.pop_front();
                    end
                    serve_count = (serve_count + 1 >= eff_period) ? 0 : serve_count + 1;
                end else if (header_q.size() != 0) begin
                    res.packet_valid = 1'b1;
                    cls = CLASS_HEADER;
                    entry = header_q.pop_front();
                end else if (data_q.size() != 0) begin
                    res.packet_valid = 1'b1;
                    cls = CLASS_DATA;
                    entry = data_q.pop_front();
                end
                if (res.packet_valid) begin
                    res.out_packet_id = entry[ID_W-1:0];
                    res.out_trimmed   = entry[ID_W];
                end
            end
            res.data_count    = COUNT_OUT_W'(data_q.size());
            res.header_count  = COUNT_OUT_W'(header_q.size());
            res.control_count = COUNT_OUT_W'(control_q.size());
            expected_results.push_back(res);
            expected_classes.push_back(cls);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            out_item_t          got;
            out_item_t          want;
            logic [CLASS_W-1:0] want_class;
            if (expected_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
                return;
            end
            got        = tdata[$bits(out_item_t)-1:0];
            want       = expected_results.pop_front();
            want_class = expected_classes.pop_front();
            compare_field("packet_valid", want.packet_valid, got.packet_valid);
            compare_field("out_packet_id", want.out_packet_id, got.out_packet_id);
            compare_field("out_trimmed", want.out_trimmed, got.out_trimmed);
            compare_field("queue_class", want_class, tuser[CLASS_W-1:0]);
            compare_field("trimmed_on_push", want.trimmed_on_push, got.trimmed_on_push);
            compare_field("dropped", want.dropped, got.dropped);
            compare_field("data_count", want.data_count, got.data_count);
            compare_field("header_count", want.header_count, got.header_count);
            compare_field("control_count", want.control_count, got.control_count);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    trim_queue_scoreboard sb = new();
    bit hold_go;
    bit hold_done;
    int burst_left;

    trimming_switch_queue_wrr #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        int run;
        int stall;
        m_tready = 1'b0;
        repeat (7) @(posedge aclk);
        forever begin
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: stall = 0;
                    9:             stall = $urandom_range(10, 60);
                    default:       stall = $urandom_range(1, 4);
                endcase
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_item_t pkt(logic [4:0] flags, logic [ID_W-1:0] id);
        return in_item_t'({flags, id});
    endfunction

    task automatic send_request(logic cmd, in_item_t req);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - $bits(in_item_t)){1'b0}}, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, req);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        repeat (12) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_register(addr, value);
    endtask

    task automatic make_request(int push_pct, int ctl_pct, int hdr_pct,
                                output logic cmd, output in_item_t req);
        logic [31:0] raw;
        int          r;
        raw = $urandom;
        req = raw[$bits(in_item_t)-1:0];
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_PULL;
        if (cmd == CMD_PUSH && $urandom_range(0, 9) != 0) begin
            r = $urandom_range(0, 99);
            if (r < ctl_pct) begin
                {req.nack_flag, req.syn_flag, req.ack_flag} = 3'($urandom_range(1, 7));
            end else if (r < ctl_pct + hdr_pct) begin
                {req.nack_flag, req.syn_flag, req.ack_flag} = 3'b000;
                {req.pull_request, req.header_only} = 2'($urandom_range(1, 3));
            end else begin
                {req.pull_request, req.header_only, req.nack_flag, req.syn_flag,
                 req.ack_flag} = F_NONE;
            end
        end
    endtask

    task automatic run_phase(int n, int push_pct, int ctl_pct, int hdr_pct);
        logic     cmd;
        in_item_t req;
        for (int i = 0; i < n; i++) begin
            make_request(push_pct, ctl_pct, hdr_pct, cmd, req);
            send_request(cmd, req);
        end
        settle();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        hold_go   = 1'b0;
        hold_done = 1'b0;
        burst_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(CMD_PULL, pkt(5'b11111, 16'hFFFF));
        send_request(CMD_PUSH, pkt(F_ACK, 16'hFFFF));
        send_request(CMD_PUSH, pkt(F_SYN, 16'h0000));
        send_request(CMD_PUSH, pkt(F_NACK, 16'h1234));
        send_request(CMD_PUSH, pkt(F_ACK | F_HDR | F_PULL, 16'hABCD));
        send_request(CMD_PUSH, pkt(F_HDR, 16'h8001));
        send_request(CMD_PUSH, pkt(F_PULL, 16'h7FFE));
        send_request(CMD_PUSH, pkt(F_HDR | F_PULL, 16'h5555));
        send_request(CMD_PUSH, pkt(F_NONE, 16'hFFFF));
        send_request(CMD_PUSH, pkt(F_NONE, 16'h0000));
        send_request(CMD_PUSH, pkt(F_NONE, 16'hAAAA));
        for (int i = 0; i < 11; i++) begin
            send_request(CMD_PULL, pkt(5'(i), 16'(i * 16'h1111)));
        end
        settle();

        run_phase(200, 55, 20, 25);

        set_register(REG_DATA_CAPACITY, 8'd0);
        set_register(REG_WRR_PERIOD, 8'd1);
        run_phase(150, 60, 10, 20);

        set_register(REG_DATA_CAPACITY, 8'd64);
        set_register(REG_WRR_PERIOD, 8'd255);
        hold_go = 1'b1;
        run_phase(300, 85, 5, 10);
        run_phase(150, 20, 5, 10);

        set_register(REG_DATA_CAPACITY, 8'd127);
        set_register(REG_WRR_PERIOD, 8'd0);
        run_phase(200, 70, 10, 30);

        set_register(REG_DATA_CAPACITY, 8'd5);
        set_register(REG_WRR_PERIOD, 8'd3);
        run_phase(200, 90, 60, 20);

        set_register(REG_WRR_PERIOD, 8'd200);
        run_phase(150, 50, 0, 40);
        set_register(REG_WRR_PERIOD, 8'd7);
        run_phase(100, 45, 5, 40);

        set_register(REG_DATA_CAPACITY, 8'd32);
        set_register(REG_WRR_PERIOD, 8'd10);
        run_phase(100, 30, 20, 30);

        repeat (20) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
src/tsq_pkg.sv
src/tsq_rem.sv
src/tsq_datapath.sv
src/tsq_ctrl.sv
src/trimming_switch_queue_wrr.sv
tb/tb.sv
